### rtl/edit_distance_engine_macros.svh
// Assertion macros used by the checker file of the edit distance engine.
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ed_pkg.sv
package ed_pkg;

  // Field widths of the words on the two channels.
  localparam int CHAR_W = 8;
  localparam int DIST_W = 5;

  // Largest distance the output field can carry.
  localparam int DIST_SAT = 31;

  typedef logic [1:0]        mode_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Operation codes carried in the mode field.
  localparam mode_t MODE_FIRST   = 2'd0;
  localparam mode_t MODE_SECOND  = 2'd1;
  localparam mode_t MODE_COMPUTE = 2'd2;
  localparam mode_t MODE_NONE    = 2'd3;

endpackage

### rtl/ed_ram.sv
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ed_cell.sv
module ed_cell #(
  parameter int VAL_W = 5
) (
  input  ed_pkg::char_t    char_a,
  input  ed_pkg::char_t    char_b,
  input  logic [VAL_W-1:0] up,
  input  logic [VAL_W-1:0] left,
  input  logic [VAL_W-1:0] diag,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W:0] del_cost;
  logic [VAL_W:0] ins_cost;
  logic [VAL_W:0] sub_cost;
  logic [VAL_W:0] min_ab;
  logic [VAL_W:0] min_all;

  // Candidate costs of deletion, insertion and substitution or match.
  assign del_cost = {1'b0, up} + (VAL_W+1)'(1);
  assign ins_cost = {1'b0, left} + (VAL_W+1)'(1);
  assign sub_cost = {1'b0, diag} + (VAL_W+1)'(char_a != char_b);

  // Smallest of the three; a table value never exceeds the word length.
  assign min_ab  = (ins_cost < del_cost) ? ins_cost : del_cost;
  assign min_all = (sub_cost < min_ab) ? sub_cost : min_ab;
  assign val     = min_all[VAL_W-1:0];

endmodule

### rtl/edit_distance_engine.sv
// Edit distance engine: Levenshtein distance between two words of up to
// MAX_LEN byte characters, unit cost for insertion, deletion, substitution.
// Input channel (in_valid, in_stall, mode, char_code): mode 0 appends a
// character to the first word, mode 1 to the second word, mode 2 computes,
// mode 3 does nothing. A word is accepted when in_valid is high and
// in_stall is low. Appends to a full word are dropped.
// Output channel (out_valid, out_stall, distance): one word per compute.
// Appends are taken without stalling. A compute walks the table one cell per
// cycle through a single cell unit, with a setup state per row, and then
// loads the output register once it is free. It holds the input stalled
// from the compute word until the output register is loaded; if either word
// is empty, it skips the walk and goes straight to that load.
// Characters and a table row live in three small RAMs with registered reads.
// A stalled output word holds; appends are still taken meanwhile, and a
// finished compute waits in place until the output register is free.
// After compute both lengths are cleared. Reset (rst, synchronous)
// empties both words and the output register; no clearing pass is needed.
module edit_distance_engine #(
  parameter int MAX_LEN = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ed_pkg::mode_t mode,
  input  ed_pkg::char_t char_code,
  output logic          out_valid,
  input  logic          out_stall,
  output ed_pkg::dist_t distance
);

  import ed_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW = (CW > DIST_W) ? CW : DIST_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROW    = 2'd1;
  localparam logic [1:0] ST_CELL   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] first_length;
  logic [CW-1:0] second_length;
  logic [CW-1:0] row_i;
  logic [CW-1:0] col_j;
  logic [CW-1:0] diag;
  logic [CW-1:0] left;
  logic [CW-1:0] result;
  logic [CW-1:0] out_result;

  logic          accept;
  logic          out_free;
  logic          first_we;
  logic          second_we;
  logic [CW-1:0] i_minus;
  logic [CW-1:0] j_minus;
  logic [AW-1:0] col_raddr;
  char_t         first_rdata;
  char_t         second_rdata;
  logic [CW-1:0] row_rdata;
  logic [CW-1:0] up;
  logic [CW-1:0] cell_val;
  logic          last_col;
  logic          last_row;
  logic [SW-1:0] res_wide;

  // Handshake: items are taken only while the sequencer is idle.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Character stores, written at the current length.
  assign first_we  = accept && (mode == MODE_FIRST) && (first_length < CW'(MAX_LEN));
  assign second_we = accept && (mode == MODE_SECOND) && (second_length < CW'(MAX_LEN));

  // Read addresses: row character stays fixed, column character and row
  // value look one column ahead of the cell being computed.
  assign i_minus   = row_i - CW'(1);
  assign j_minus   = col_j - CW'(1);
  assign col_raddr = (state == ST_CELL) ? col_j[AW-1:0] : '0;

  ed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_length[AW-1:0]),
    .wdata (char_code),
    .raddr (i_minus[AW-1:0]),
    .rdata (first_rdata)
  );

  ed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_length[AW-1:0]),
    .wdata (char_code),
    .raddr (col_raddr),
    .rdata (second_rdata)
  );

  // One table row; entry j-1 holds column j, column zero is implied.
  ed_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_row_ram (
    .clk   (clk),
    .we    (state == ST_CELL),
    .waddr (j_minus[AW-1:0]),
    .wdata (cell_val),
    .raddr (col_raddr),
    .rdata (row_rdata)
  );

  // The first row of the table is the column index itself.
  assign up = (row_i == CW'(1)) ? col_j : row_rdata;

  ed_cell #(.VAL_W(CW)) u_cell (
    .char_a (first_rdata),
    .char_b (second_rdata),
    .up     (up),
    .left   (left),
    .diag   (diag),
    .val    (cell_val)
  );

  assign last_col = (col_j == second_length);
  assign last_row = (row_i == first_length);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_COMPUTE)) begin
          if ((first_length == '0) || (second_length == '0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        state_next = ST_CELL;
      end
      ST_CELL: begin
        if (last_col) begin
          state_next = last_row ? ST_FINISH : ST_ROW;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_length  <= '0;
      second_length <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (first_we) begin
        first_length <= first_length + CW'(1);
      end
      if (second_we) begin
        second_length <= second_length + CW'(1);
      end
      if ((state == ST_FINISH) && out_free) begin
        first_length  <= '0;
        second_length <= '0;
        out_valid     <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table walk registers and the output word.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        row_i <= CW'(1);
        if (first_length == '0) begin
          result <= second_length;
        end else begin
          result <= first_length;
        end
      end
      ST_ROW: begin
        col_j <= CW'(1);
        diag  <= i_minus;
        left  <= row_i;
      end
      ST_CELL: begin
        diag <= up;
        left <= cell_val;
        if (last_col) begin
          row_i  <= row_i + CW'(1);
          result <= cell_val;
        end else begin
          col_j <= col_j + CW'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_result <= result;
        end
      end
      default: begin
      end
    endcase
  end

  // Saturate to the width of the distance field.
  assign res_wide = SW'(out_result);
  assign distance = (res_wide > SW'(DIST_SAT)) ? dist_t'(DIST_SAT) : res_wide[DIST_W-1:0];

endmodule

### rtl/ed_checker.sv
module ed_checker #(
  parameter int MAX_LEN = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input ed_pkg::mode_t mode,
  input ed_pkg::char_t char_code,
  input logic          out_valid,
  input logic          out_stall,
  input ed_pkg::dist_t distance
);

  import ed_pkg::*;

  `include "edit_distance_engine_macros.svh"

  localparam int DIST_TOP = (MAX_LEN < DIST_SAT) ? MAX_LEN : DIST_SAT;

  logic in_take;
  logic char_seen;

  assign in_take   = in_valid && !in_stall;
  assign char_seen = (char_code == char_code);

  // A stalled output word must hold.
  `ED_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(distance), "output word changed while stalled")

  // A compute occupies the engine for at least the following cycle.
  `ED_ASSERT_NEXT(a_compute_busy, clk, rst, in_take && (mode == MODE_COMPUTE), in_stall, "engine ready right after a compute")

  // An append or no-op word taken while no result word is pending produces none.
  `ED_ASSERT_NEXT(a_append_silent, clk, rst, in_take && (mode != MODE_COMPUTE) && !out_valid && char_seen, !out_valid, "result word after an append")

  // The distance cannot exceed MAX_LEN, nor the saturation value DIST_SAT.
  `ED_ASSERT_NOW(a_dist_range, clk, rst, out_valid, distance <= DIST_W'(DIST_TOP), "distance beyond word length")

endmodule

bind edit_distance_engine ed_checker #(.MAX_LEN(MAX_LEN)) u_ed_checker (.*);
